// ===== sv/sidw_pkg.sv =====
// Shared types, constants and sequencer states of the socket weight core.
`default_nettype none
package sidw_pkg;
	localparam int MaxSockets = 16;
	localparam int SlotW = $clog2(MaxSockets);
	localparam int CountW = $clog2(MaxSockets + 1);
	localparam int DivW = 49;
	localparam int DivCntW = 6;

	typedef enum logic [1:0] {
		REG_ACTIVE_SOCKETS = 2'd0,
		REG_MIN_DISTANCE_SQ = 2'd1,
		REG_EQUAL_TOLERANCE = 2'd2,
		REG_ALIGN_COS_SQ = 2'd3
	} cfg_reg_t;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_VERTEX = 1'b1;

	typedef struct packed {
		logic action;
		logic [3:0] socket_slot;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_z;
	} in_item_t;

	typedef struct packed {
		logic [3:0] weight_socket;
		logic [16:0] weight;
		logic is_main;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [DivCntW-1:0] count;
		logic [DivW-1:0] rem_init;
		logic [DivW-1:0] low_init;
		logic [DivW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DivW-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
		S_M9, S_M10, S_CMP, S_DIV1, S_W, S_DIV2, S_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== sv/sidw_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module sidw_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire sidw_pkg::div_req_t req,
	output sidw_pkg::div_rsp_t rsp
);
	import sidw_pkg::*;

	logic busy_q;
	logic done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] low_q;
	logic [DivW-1:0] quo_q;
	logic [DivW-1:0] div_q;
	logic [DivW:0] trial;
	logic fits;

	assign trial = {rem_q, low_q[DivW-1]};
	assign fits = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= req.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DivCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			low_q <= req.low_init;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			low_q <= {low_q[DivW-2:0], 1'b0};
			if (fits) begin
				rem_q <= DivW'(trial - {1'b0, div_q});
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// ===== sv/socket_inverse_distance_weights_core.sv =====
// Top level of the socket inverse squared distance weight core.
// Load transactions (action 0) write one socket entry.
// Vertex transactions (action 1) yield one weight transaction per active
// socket, in socket order, with last set on the final one.
// A vertex runs two passes over the active sockets on one shared 32 by 32
// multiplier and one shared radix-2 divider. In the first pass each socket
// takes thirteen difference, multiply and compare steps, then a 45-bit
// reciprocal on the divider. In the second pass each socket takes a 17-bit
// weight quotient on the divider, or skips it when a main socket was found.
// The input is not ready while a vertex is in progress.
// When the receiver stalls, the block holds the current weight and waits.
// Configuration writes are taken at any time and must be made while idle.
// Reset restores the register defaults; socket entries must be loaded
// before a vertex uses them.
`default_nettype none
module socket_inverse_distance_weights_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sidw_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output sidw_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire sidw_pkg::cfg_reg_t cfg_index,
	input wire logic [24:0] cfg_data
);
	import sidw_pkg::*;

	state_t state_q, state_d;

	logic [4:0] active_q;
	logic [24:0] min_dsq_q;
	logic [11:0] tol_q;
	logic [15:0] acs_q;

	logic signed [23:0] ox_tab [MaxSockets];
	logic signed [23:0] oz_tab [MaxSockets];
	logic signed [15:0] ax_tab [MaxSockets];
	logic signed [15:0] az_tab [MaxSockets];
	logic [31:0] inv_tab [MaxSockets];

	logic signed [23:0] vx_q, vz_q;
	logic [CountW-1:0] n_q;
	logic [24:0] floor_q;
	logic [SlotW-1:0] k_q;
	logic signed [24:0] dx_q, dz_q;
	logic [48:0] dsq_q;
	logic signed [40:0] dot_q;
	logic [79:0] lhs_q, rhs_q;
	logic [35:0] sum_q;
	logic best_q;
	logic [SlotW-1:0] best_k_q;
	logic [48:0] best_d_q;
	logic [63:0] prod_q;
	out_item_t out_q;

	logic [31:0] mul_a, mul_b;
	logic [23:0] adx, adz;
	logic [15:0] aax, aaz;
	logic sx, sz;
	logic [39:0] adot;
	logic [48:0] clamp_d;
	logic cand, is_last;
	logic [31:0] inv_sat;
	logic [48:0] num;
	logic [CountW-1:0] n_sat;
	logic [4:0] act_lim;
	div_req_t div_req;
	div_rsp_t div_rsp;

	sidw_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic signed [24:0] ndx, ndz;
	logic signed [16:0] nax, naz;
	logic signed [40:0] ndot;
	assign ndx = -dx_q;
	assign ndz = -dz_q;
	assign adx = dx_q[24] ? ndx[23:0] : dx_q[23:0];
	assign adz = dz_q[24] ? ndz[23:0] : dz_q[23:0];
	assign nax = -17'(ax_tab[k_q]);
	assign naz = -17'(az_tab[k_q]);
	assign aax = ax_tab[k_q][15] ? nax[15:0] : ax_tab[k_q];
	assign aaz = az_tab[k_q][15] ? naz[15:0] : az_tab[k_q];
	assign sx = dx_q[24] ^ ax_tab[k_q][15];
	assign sz = dz_q[24] ^ az_tab[k_q][15];
	assign ndot = -dot_q;
	assign adot = dot_q[40] ? ndot[39:0] : dot_q[39:0];
	assign clamp_d = (dsq_q < 49'(floor_q)) ? 49'(floor_q) : dsq_q;
	assign cand = (lhs_q > rhs_q) || ((adx <= 24'(tol_q)) && (adz <= 24'(tol_q)));
	assign is_last = (CountW'(k_q) + 1'b1) == n_q;
	assign act_lim = (active_q > 5'(MaxSockets)) ? 5'(MaxSockets) : active_q;
	assign n_sat = (act_lim > 5'd16) ? CountW'(16) : CountW'(act_lim);
	assign inv_sat = (div_rsp.quotient > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF :
		((div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient[31:0]);
	assign num = {1'b0, inv_tab[k_q], 16'd0} + 49'(sum_q[35:1]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_M0: begin mul_a = 32'(adx); mul_b = 32'(adx); end
			S_M1: begin mul_a = 32'(adz); mul_b = 32'(adz); end
			S_M2: begin mul_a = 32'(adx); mul_b = 32'(aax); end
			S_M3: begin mul_a = 32'(adz); mul_b = 32'(aaz); end
			S_M5: begin mul_a = 32'(adot[39:20]); mul_b = 32'(adot[39:20]); end
			S_M6: begin mul_a = 32'(adot[39:20]); mul_b = 32'(adot[19:0]); end
			S_M7: begin mul_a = 32'(adot[19:0]); mul_b = 32'(adot[19:0]); end
			S_M8: begin mul_a = 32'(acs_q); mul_b = 32'(dsq_q[24:0]); end
			S_M9: begin mul_a = 32'(acs_q); mul_b = 32'(dsq_q[48:25]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		div_req = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_data.action == ACT_VERTEX && n_sat != '0) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: state_d = S_M0;
			S_M0: state_d = S_M1;
			S_M1: state_d = S_M2;
			S_M2: state_d = S_M3;
			S_M3: state_d = S_M4;
			S_M4: state_d = S_M5;
			S_M5: state_d = S_M6;
			S_M6: state_d = S_M7;
			S_M7: state_d = S_M8;
			S_M8: state_d = S_M9;
			S_M9: state_d = S_M10;
			S_M10: state_d = S_CMP;
			S_CMP: begin
				div_req.start = 1'b1;
				div_req.count = DivCntW'(45);
				div_req.low_init = {1'b1, 48'd0};
				div_req.divisor = clamp_d;
				state_d = S_DIV1;
			end
			S_DIV1: begin
				if (div_rsp.done) begin
					state_d = is_last ? S_W : S_DIFF;
				end
			end
			S_W: begin
				if (best_q) begin
					state_d = S_OUT;
				end else begin
					div_req.start = 1'b1;
					div_req.count = DivCntW'(17);
					div_req.rem_init = 49'(num[48:17]);
					div_req.low_init = {num[16:0], 32'd0};
					div_req.divisor = 49'(sum_q);
					state_d = S_DIV2;
				end
			end
			S_DIV2: begin
				if (div_rsp.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = out_q.last ? S_IDLE : S_W;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd1;
			min_dsq_q <= 25'd16777;
			tol_q <= 12'd1;
			acs_q <= 16'd65405;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACTIVE_SOCKETS: active_q <= cfg_data[4:0];
				REG_MIN_DISTANCE_SQ: min_dsq_q <= cfg_data;
				REG_EQUAL_TOLERANCE: tol_q <= cfg_data[11:0];
				REG_ALIGN_COS_SQ: acs_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_data.action == ACT_LOAD) begin
			ox_tab[in_data.socket_slot[SlotW-1:0]] <= in_data.pos_x;
			oz_tab[in_data.socket_slot[SlotW-1:0]] <= in_data.pos_z;
			ax_tab[in_data.socket_slot[SlotW-1:0]] <= in_data.axis_x;
			az_tab[in_data.socket_slot[SlotW-1:0]] <= in_data.axis_z;
		end
		if (state_q == S_DIV1 && div_rsp.done) begin
			inv_tab[k_q] <= inv_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			best_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					k_q <= '0;
					best_q <= 1'b0;
				end
				S_CMP: begin
					if (cand && (!best_q || dsq_q < best_d_q)) begin
						best_q <= 1'b1;
					end
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						k_q <= is_last ? '0 : k_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				vx_q <= in_data.pos_x;
				vz_q <= in_data.pos_z;
				n_q <= n_sat;
				floor_q <= (min_dsq_q == '0) ? 25'd1 : min_dsq_q;
				sum_q <= '0;
			end
			S_DIFF: begin
				dx_q <= 25'(ox_tab[k_q]) - 25'(vx_q);
				dz_q <= 25'(oz_tab[k_q]) - 25'(vz_q);
			end
			S_M1: dsq_q <= prod_q[48:0];
			S_M2: dsq_q <= dsq_q + prod_q[48:0];
			S_M3: dot_q <= sx ? -$signed({2'b0, prod_q[38:0]}) : $signed({2'b0, prod_q[38:0]});
			S_M4: dot_q <= sz ? dot_q - $signed({2'b0, prod_q[38:0]})
				: dot_q + $signed({2'b0, prod_q[38:0]});
			S_M6: lhs_q <= 80'(prod_q) << 40;
			S_M7: lhs_q <= lhs_q + (80'(prod_q) << 21);
			S_M8: lhs_q <= lhs_q + 80'(prod_q);
			S_M9: rhs_q <= 80'(prod_q) << 12;
			S_M10: rhs_q <= rhs_q + (80'(prod_q) << 37);
			S_CMP: begin
				if (cand && (!best_q || dsq_q < best_d_q)) begin
					best_k_q <= k_q;
					best_d_q <= dsq_q;
				end
			end
			S_DIV1: begin
				if (div_rsp.done) begin
					sum_q <= sum_q + 36'(inv_sat);
				end
			end
			S_W: begin
				out_q.weight_socket <= 4'(k_q);
				out_q.is_main <= best_q;
				out_q.last <= is_last;
				out_q.weight <= (k_q == best_k_q) ? 17'h10000 : 17'd0;
			end
			S_DIV2: begin
				if (div_rsp.done) begin
					out_q.weight <= div_rsp.quotient[16:0];
				end
			end
			default: ;
		endcase
	end

	assign out_data = out_q;
endmodule
`default_nettype wire
